// File: src/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types, marker table and helper functions for the weighted marker
// scanner: beat structs, per-marker constants and match-table builders.
// ----------------------------------------------------------------------------
`default_nettype none

package wms_pkg;

    // Sizes
    localparam int NUM_MARKERS = 11;
    localparam int MAX_LEN     = 12;
    localparam int LEN_W       = 4;
    localparam int TEXT_W      = 8 * MAX_LEN;
    localparam int WEIGHT_W    = 6;
    localparam int NUM_CLS     = 4;
    localparam int CLS_W       = 2;
    localparam int COUNT_WIDTH = 32;
    localparam int TOTAL_W     = 36;
    localparam int SUM_W       = ((COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W) + 1;
    localparam int SCORE_W     = 9;
    localparam int BONUS_W     = SCORE_W + 1;
    localparam int CONF_W      = 7;

    // Score constants
    localparam logic [CONF_W-1:0]  SCORE_CAP   = CONF_W'(100);
    localparam logic [BONUS_W-1:0] BONUS_PAIR  = BONUS_W'(10);
    localparam logic [BONUS_W-1:0] BONUS_MINOR = BONUS_W'(5);

    // Marker classes
    localparam logic [CLS_W-1:0] CLS_INK   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SIG   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_TEXT  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_ANNOT = 2'd3;

    // Input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    // Result beat
    typedef struct packed {
        logic [TOTAL_W-1:0] hit_total;
        logic [CONF_W-1:0]  confidence;
        logic               detected;
    } result_t;

    // Beat travelling down the cell chain, with running summary
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last_byte;
        logic [TOTAL_W-1:0] total;
        logic [SCORE_W-1:0] score;
        logic [NUM_CLS-1:0] cls;
    } chain_beat_t;

    // One marker: lower-case text right-justified, length, weight, class
    typedef struct packed {
        logic [TEXT_W-1:0]   text;
        logic [LEN_W-1:0]    len;
        logic [WEIGHT_W-1:0] weight;
        logic [CLS_W-1:0]    cls;
    } marker_t;

    typedef logic [MAX_LEN-1:0][7:0]       chars_t;
    typedef logic [MAX_LEN-1:0][MAX_LEN:1] border_t;

    localparam marker_t MARKERS [NUM_MARKERS] = '{
        '{"/subtype/ink", 4'd12, 6'd45, CLS_INK},
        '{"inklist",      4'd7,  6'd30, CLS_INK},
        '{"/ink",         4'd4,  6'd20, CLS_INK},
        '{"/sig",         4'd4,  6'd25, CLS_SIG},
        '{"signature",    4'd9,  6'd25, CLS_SIG},
        '{"handwriting",  4'd11, 6'd35, CLS_TEXT},
        '{"handwritten",  4'd11, 6'd35, CLS_TEXT},
        '{"/freetext",    4'd9,  6'd15, CLS_ANNOT},
        '{"/stamp",       4'd6,  6'd10, CLS_ANNOT},
        '{"/annot",       4'd6,  6'd10, CLS_ANNOT},
        '{"/annots",      4'd7,  6'd10, CLS_ANNOT}
    };

    // ASCII upper case folds to lower case; everything else passes
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Marker characters, first character at index 0
    function automatic chars_t marker_chars(input marker_t m);
        chars_t ch;
        ch = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (i < int'(m.len))
            begin
                ch[i] = m.text[8 * (int'(m.len) - 1 - i) +: 8];
            end
        end
        return ch;
    endfunction

    // b[p][k]: with p bytes matched, the first k-1 marker bytes equal the
    // last k-1 matched bytes (so prefix k holds if byte k-1 matches too)
    function automatic border_t marker_border(input marker_t m);
        chars_t  ch;
        border_t b;
        logic    ok;
        ch = marker_chars(m);
        b  = '0;
        for (int p = 0; p < MAX_LEN; p++)
        begin
            for (int k = 1; k <= MAX_LEN; k++)
            begin
                ok = (k <= p + 1);
                for (int i = 0; i < MAX_LEN - 1; i++)
                begin
                    if (ok && (i + 1 < k))
                    begin
                        ok = (ch[i] == ch[p - k + 1 + i]);
                    end
                end
                b[p][k] = ok;
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: src/weighted_marker_scanner_unit.sv
// ----------------------------------------------------------------------------
// weighted_marker_scanner_unit
// Case-insensitive scanner for eleven fixed markers with weighted scoring.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and passes it down a chain of
// eleven matcher cells, one per marker, each one register stage long. Every
// cell keeps its marker's match progress and a saturating hit count. The
// beat flagged last_byte collects each cell's count and score share on its
// way down the chain, clearing the cell behind it, and the scoring stage
// turns it into one result beat: total hits, confidence (0..100) and a
// detected flag. Throughput is one byte per cycle unless the input is
// stalled; a last beat passes the eleven cell stages and then the output
// register, the first stage loading on the edge that accepts it.
// Input is stalled only while a last beat sits at the end of the chain and
// the previous result is still held by result_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_marker_scanner_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire wms_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output wms_pkg::result_t      result
);
    import wms_pkg::*;

    chain_beat_t beat  [NUM_MARKERS+1];
    logic        valid [NUM_MARKERS+1];
    logic        advance;
    logic        can_take;

    // Chain entry: fold case once, start with an empty summary
    always_comb
    begin
        beat[0].data_byte = fold_case(item.data_byte);
        beat[0].last_byte = item.last_byte;
        beat[0].total     = '0;
        beat[0].score     = '0;
        beat[0].cls       = '0;
    end
    assign valid[0] = item_valid;

    // Chain moves unless a last beat at its end cannot be taken
    assign advance    = !(valid[NUM_MARKERS] && beat[NUM_MARKERS].last_byte) || can_take;
    assign item_stall = !advance;

    // Matcher cells
    for (genvar g = 0; g < NUM_MARKERS; g++)
    begin : g_cell
        wms_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .marker    (MARKERS[g]),
            .advance   (advance),
            .in_valid  (valid[g]),
            .in_beat   (beat[g]),
            .out_valid (valid[g+1]),
            .out_beat  (beat[g+1])
        );
    end

    // Scoring and output register
    wms_score u_score (
        .clk          (clk),
        .rst_n        (rst_n),
        .end_valid    (valid[NUM_MARKERS]),
        .end_beat     (beat[NUM_MARKERS]),
        .can_take     (can_take),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // Input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a held result");

    // Hits and confidence are zero together
    a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.hit_total == '0) == (result.confidence == '0)))
        else $error("hit total and confidence disagree");

    // Confidence is capped and detected follows it
    a_conf_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.confidence <= SCORE_CAP) &&
                          (result.detected == (result.confidence != '0))))
        else $error("confidence out of range or detected wrong");
`endif

endmodule

`default_nettype wire

// File: src/wms_cell.sv
// ----------------------------------------------------------------------------
// wms_cell
// One matcher cell: tracks match progress and a saturating hit count for one
// marker, and on the last beat folds its count into the running summary.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wms_pkg::marker_t     marker,
    input  wire logic                 advance,
    input  wire logic                 in_valid,
    input  wire wms_pkg::chain_beat_t in_beat,
    output logic                      out_valid,
    output wms_pkg::chain_beat_t      out_beat
);
    import wms_pkg::*;

    chars_t                chars;
    border_t               border;
    logic [LEN_W-1:0]      p_eff;
    logic [LEN_W-1:0]      np;
    logic                  hit;
    logic [COUNT_WIDTH-1:0] count_after;
    logic [SUM_W-1:0]      sum;
    logic [SCORE_W-1:0]    add;
    logic [NUM_CLS-1:0]    cls_bit;

    logic [LEN_W-1:0]       progress_reg, progress_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   out_valid_reg;
    chain_beat_t            out_beat_reg, beat_next;

    localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'((64'd1 << TOTAL_W) - 64'd1);

    assign chars  = marker_chars(marker);
    assign border = marker_border(marker);

    // Match step and counter update
    always_comb
    begin
        p_eff = (progress_reg >= marker.len) ? '0 : progress_reg;
        np    = '0;
        for (int k = 1; k <= MAX_LEN; k++)
        begin
            if ((k <= int'(marker.len)) && (chars[k-1] == in_beat.data_byte) &&
                border[p_eff][k])
            begin
                np = LEN_W'(k);
            end
        end
        hit         = (np == marker.len);
        count_after = count_reg;
        if (hit && (count_reg != '1))
        begin
            count_after = count_reg + COUNT_WIDTH'(1);
        end
        if (in_beat.last_byte)
        begin
            progress_next = '0;
            count_next    = '0;
        end
        else
        begin
            progress_next = hit ? '0 : np;
            count_next    = count_after;
        end
    end

    // Summary contribution on the last beat
    always_comb
    begin
        sum = SUM_W'(in_beat.total) + SUM_W'(count_after);
        add = '0;
        if (count_after != '0)
        begin
            add = add + SCORE_W'(marker.weight);
        end
        if (count_after > COUNT_WIDTH'(1))
        begin
            add = add + SCORE_W'(marker.weight >> 1);
        end
        if (count_after > COUNT_WIDTH'(2))
        begin
            add = add + SCORE_W'(marker.weight >> 2);
        end
        cls_bit = (count_after != '0) ? (NUM_CLS'(1) << marker.cls) : '0;

        beat_next       = in_beat;
        beat_next.total = (sum > TOTAL_MAX) ? '1 : sum[TOTAL_W-1:0];
        beat_next.score = in_beat.score + add;
        beat_next.cls   = in_beat.cls | cls_bit;
    end

    // Cell state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= '0;
            count_reg    <= '0;
        end
        else if (advance && in_valid)
        begin
            progress_reg <= progress_next;
            count_reg    <= count_next;
        end
    end

    // Stage register toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            out_beat_reg <= beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

`ifndef SYNTHESIS
    // Progress never reaches the full marker length
    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg < marker.len)
        else $error("progress out of range");

    // Last beat leaves the cell cleared
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid && in_beat.last_byte) |=>
        (progress_reg == '0) && (count_reg == '0))
        else $error("cell state not cleared after last beat");

    // A moving chain hands the input valid on to the next stage
    a_valid_follow: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid == $past(in_valid)))
        else $error("stage valid lost or invented");
`endif

endmodule

`default_nettype wire

// File: src/wms_score.sv
// ----------------------------------------------------------------------------
// wms_score
// Final scoring: adds class bonuses, caps the score, and holds the result
// beat in the output register until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wms_score (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 end_valid,
    input  wire wms_pkg::chain_beat_t end_beat,
    output logic                      can_take,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output wms_pkg::result_t          result
);
    import wms_pkg::*;

    logic [BONUS_W-1:0] score_sum;
    logic               ink, sig, txt, ann;
    result_t            res_next;
    logic               result_valid_reg;
    result_t            result_reg;

    assign ink = end_beat.cls[CLS_INK];
    assign sig = end_beat.cls[CLS_SIG];
    assign txt = end_beat.cls[CLS_TEXT];
    assign ann = end_beat.cls[CLS_ANNOT];

    // Bonuses, cap, zero when nothing was hit
    always_comb
    begin
        score_sum = BONUS_W'(end_beat.score);
        if (ink && sig)
        begin
            score_sum = score_sum + BONUS_PAIR;
        end
        if (ink && txt)
        begin
            score_sum = score_sum + BONUS_PAIR;
        end
        if (sig && txt)
        begin
            score_sum = score_sum + BONUS_MINOR;
        end
        if (ann && (ink || sig))
        begin
            score_sum = score_sum + BONUS_MINOR;
        end

        res_next.hit_total = end_beat.total;
        if (end_beat.total == '0)
        begin
            res_next.confidence = '0;
        end
        else if (score_sum > BONUS_W'(SCORE_CAP))
        begin
            res_next.confidence = SCORE_CAP;
        end
        else
        begin
            res_next.confidence = score_sum[CONF_W-1:0];
        end
        res_next.detected = (res_next.confidence != '0);
    end

    assign can_take = !result_valid_reg || !result_stall;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (can_take)
        begin
            result_valid_reg <= end_valid && end_beat.last_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && end_valid && end_beat.last_byte)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: bench/weighted_marker_scanner_unit_tb.sv
// ----------------------------------------------------------------------------
// weighted_marker_scanner_unit_tb
// Self-checking bench for the weighted marker scanner.
// ----------------------------------------------------------------------------
// Bytes are sent as files, each closed by a beat with last_byte set. A short
// table of directed files comes first: no-hit files at the byte extremes,
// single markers and one marker pair in mixed case. Random files follow.
// They are built mostly from marker text with random case, repeated or cut
// short, and mixed with noise bytes. Every accepted byte goes through a
// scoring model in the bench. Every result beat is compared field by field
// with the oldest predicted score. The run steps through several sender
// idle and receiver stall settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module weighted_marker_scanner_unit_tb;

    localparam int MARKS       = 11;
    localparam int RAND_BYTES  = 1260;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASES      = 4;

    localparam logic [35:0] TOTAL_SAT = 36'hF_FFFF_FFFF;
    localparam int          CAP_SCORE = 100;

    // Marker text (lower case, right-justified), length, weight and class
    localparam logic [95:0] MARK_TEXT [MARKS] = '{
        "/subtype/ink", "inklist", "/ink", "/sig", "signature", "handwriting",
        "handwritten", "/freetext", "/stamp", "/annot", "/annots"
    };
    localparam int MARK_LEN [MARKS] = '{12, 7, 4, 4, 9, 11, 11, 9, 6, 6, 7};
    localparam int MARK_WT  [MARKS] = '{45, 30, 20, 25, 25, 35, 35, 15, 10, 10, 10};
    localparam logic [1:0] MARK_CLS [MARKS] = '{
        wms_pkg::CLS_INK,   wms_pkg::CLS_INK,   wms_pkg::CLS_INK,
        wms_pkg::CLS_SIG,   wms_pkg::CLS_SIG,
        wms_pkg::CLS_TEXT,  wms_pkg::CLS_TEXT,
        wms_pkg::CLS_ANNOT, wms_pkg::CLS_ANNOT, wms_pkg::CLS_ANNOT,
        wms_pkg::CLS_ANNOT
    };

    // Directed files: text right-justified, length, known score if typed
    typedef struct packed {
        logic [95:0]      text;
        logic [3:0]       len;
        logic             typed;
        wms_pkg::result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 6;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{96'h00,      4'd1, 1'b1, '{36'd0, 7'd0,  1'b0}},
        '{96'hFF,      4'd1, 1'b1, '{36'd0, 7'd0,  1'b0}},
        '{"/INk",      4'd4, 1'b1, '{36'd1, 7'd20, 1'b1}},
        '{"/sIG",      4'd4, 1'b1, '{36'd1, 7'd25, 1'b1}},
        '{"/Annot",    4'd6, 1'b1, '{36'd1, 7'd10, 1'b1}},
        '{"/SIG/Ink",  4'd8, 1'b0, '0}
    };

    // Sender idle / receiver stall percentages per phase
    localparam int PHASE_IDLE  [PHASES] = '{0, 88, 0, 8};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 88, 8};

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    wms_pkg::item_t     item;
    logic               result_valid;
    logic               result_stall;
    wms_pkg::result_t   result;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 cycle_count;
    int                 error_count;
    int                 bytes_sent;
    int                 files_scanned;
    int                 scores_checked;

    // Scoring model state
    logic [3:0]         mark_pos  [MARKS];
    logic [31:0]        mark_hits [MARKS];
    wms_pkg::result_t   expected_scores [$];
    wms_pkg::result_t   typed_scores [int];
    logic [7:0]         file_bytes [$];

    weighted_marker_scanner_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d scores still pending",
                     cycle_count, expected_scores.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall
    initial result_stall = 1'b0;
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [7:0] mark_char(input int m, input int i);
        return MARK_TEXT[m][8 * (MARK_LEN[m] - 1 - i) +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if ((c >= "A") && (c <= "Z"))
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Longest marker prefix that ends at byte c, given p bytes matched
    function automatic int next_progress(input int m, input int p, input logic [7:0] c);
        int  q;
        logic ok;
        q = (p >= MARK_LEN[m]) ? 0 : p;
        for (int k = q + 1; k >= 1; k--)
        begin
            ok = (mark_char(m, k - 1) == c);
            for (int i = 0; i + 1 < k; i++)
            begin
                if (ok && (mark_char(m, i) != mark_char(m, q - k + 1 + i)))
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    function automatic void clear_scan();
        for (int m = 0; m < MARKS; m++)
        begin
            mark_pos[m]  = '0;
            mark_hits[m] = '0;
        end
    endfunction

    // Advance every matcher by one byte; on the last byte score the file
    task automatic scan_byte(input wms_pkg::item_t b);
        logic [7:0]       c;
        logic [63:0]      sum;
        logic [3:0]       cls_seen;
        int               score;
        int               np;
        wms_pkg::result_t r;
        c = to_lower(b.data_byte);
        for (int m = 0; m < MARKS; m++)
        begin
            np = next_progress(m, int'(mark_pos[m]), c);
            if (np == MARK_LEN[m])
            begin
                if (mark_hits[m] != '1)
                begin
                    mark_hits[m] = mark_hits[m] + 1;
                end
                np = 0;
            end
            mark_pos[m] = np[3:0];
        end
        if (b.last_byte)
        begin
            sum      = '0;
            score    = 0;
            cls_seen = '0;
            for (int m = 0; m < MARKS; m++)
            begin
                sum = sum + 64'(mark_hits[m]);
                if (sum > 64'(TOTAL_SAT))
                begin
                    sum = 64'(TOTAL_SAT);
                end
                if (mark_hits[m] > 0)
                begin
                    score = score + MARK_WT[m];
                    cls_seen[MARK_CLS[m]] = 1'b1;
                end
                if (mark_hits[m] > 1)
                begin
                    score = score + MARK_WT[m] / 2;
                end
                if (mark_hits[m] > 2)
                begin
                    score = score + MARK_WT[m] / 4;
                end
            end
            if (sum == 0)
            begin
                score = 0;
            end
            else
            begin
                if (cls_seen[wms_pkg::CLS_INK] && cls_seen[wms_pkg::CLS_SIG])
                begin
                    score = score + 10;
                end
                if (cls_seen[wms_pkg::CLS_INK] && cls_seen[wms_pkg::CLS_TEXT])
                begin
                    score = score + 10;
                end
                if (cls_seen[wms_pkg::CLS_SIG] && cls_seen[wms_pkg::CLS_TEXT])
                begin
                    score = score + 5;
                end
                if (cls_seen[wms_pkg::CLS_ANNOT] &&
                    (cls_seen[wms_pkg::CLS_INK] || cls_seen[wms_pkg::CLS_SIG]))
                begin
                    score = score + 5;
                end
                if (score > CAP_SCORE)
                begin
                    score = CAP_SCORE;
                end
            end
            r.hit_total  = sum[35:0];
            r.confidence = score[6:0];
            r.detected   = (score > 0);
            // directed files carry a hand-written score
            if (typed_scores.exists(files_scanned))
            begin
                r = typed_scores[files_scanned];
            end
            expected_scores.push_back(r);
            files_scanned++;
            clear_scan();
        end
    endtask

    task automatic check_score(input wms_pkg::result_t got);
        wms_pkg::result_t want;
        if (expected_scores.size() == 0)
        begin
            $error("unexpected result beat: hit_total %0d confidence %0d",
                   got.hit_total, got.confidence);
            error_count++;
        end
        else
        begin
            want = expected_scores.pop_front();
            scores_checked++;
            if (got.hit_total !== want.hit_total)
            begin
                $error("hit_total: expected %0d, actual %0d", want.hit_total, got.hit_total);
                error_count++;
            end
            if (got.confidence !== want.confidence)
            begin
                $error("confidence: expected %0d, actual %0d", want.confidence, got.confidence);
                error_count++;
            end
            if (got.detected !== want.detected)
            begin
                $error("detected: expected %0d, actual %0d", want.detected, got.detected);
                error_count++;
            end
        end
    endtask

    // Beat monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                check_score(result);
            end
            if (item_valid && !item_stall)
            begin
                scan_byte(item);
            end
        end
    end

    // One input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [7:0] d, input logic l);
        wms_pkg::item_t b;
        b.data_byte = d;
        b.last_byte = l;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= b;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Random file: marker text in random case, repeats, cut-off markers, noise
    function automatic void build_file();
        int         pieces;
        int         m;
        int         plen;
        int         reps;
        logic [7:0] ch;
        file_bytes.delete();
        pieces = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
        for (int p = 0; p < pieces; p++)
        begin
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    file_bytes.push_back(8'($urandom_range(255)));
                end
            end
            else
            begin
                m    = $urandom_range(MARKS - 1);
                plen = MARK_LEN[m];
                if ($urandom_range(4) == 0)
                begin
                    plen = $urandom_range(plen - 1, 1);
                end
                reps = ($urandom_range(4) == 0) ? $urandom_range(4, 2) : 1;
                repeat (reps)
                begin
                    for (int i = 0; i < plen; i++)
                    begin
                        ch = mark_char(m, i);
                        if ((ch >= "a") && (ch <= "z") && ($urandom_range(1) == 1))
                        begin
                            ch = ch - 8'h20;
                        end
                        file_bytes.push_back(ch);
                    end
                end
            end
        end
    endfunction

    // Main sequence
    initial
    begin
        int phase_bytes;
        int n;
        error_count    = 0;
        bytes_sent     = 0;
        files_scanned  = 0;
        scores_checked = 0;
        clear_scan();
        rst_n          <= 1'b0;
        item_valid     <= 1'b0;
        item           <= '0;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (DIR_TABLE[r].typed)
            begin
                typed_scores[r] = DIR_TABLE[r].want;
            end
        end
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            n = int'(DIR_TABLE[r].len);
            for (int i = 0; i < n; i++)
            begin
                send_beat(DIR_TABLE[r].text[8 * (n - 1 - i) +: 8], (i == n - 1));
            end
        end

        // Random files over each idle/stall setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct  <= PHASE_IDLE[ph];
            recv_stall_pct <= PHASE_STALL[ph];
            phase_bytes = 0;
            while (phase_bytes < RAND_BYTES / PHASES)
            begin
                build_file();
                n = file_bytes.size();
                for (int i = 0; i < n; i++)
                begin
                    send_beat(file_bytes[i], (i == n - 1));
                end
                phase_bytes += n;
            end
        end
        item_valid <= 1'b0;

        // Drain
        while (expected_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d bytes in %0d files over %0d idle/stall settings;",
                 bytes_sent, files_scanned, PHASES);
        $display("%0d scores checked, %0d mismatches.", scores_checked, error_count);
        if ((error_count == 0) && (expected_scores.size() == 0))
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
